// ===== rtl/owb_pkg.sv =====
`default_nettype none

package owb_pkg;

  localparam int unsigned TimeWidth = 10;
  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned ZeroRecoveryUsDefault = 6;

  typedef logic [TimeWidth-1:0] timing_t;
  typedef timing_t [NumRegs-1:0] timing_regs_t;

  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActReset = 2'd1,
    ActWrite = 2'd2,
    ActRead  = 2'd3
  } action_e;

  localparam logic [RegIdxW-1:0] RegResetLow     = 3'd0;
  localparam logic [RegIdxW-1:0] RegPresenceWait = 3'd1;
  localparam logic [RegIdxW-1:0] RegPresenceTail = 3'd2;
  localparam logic [RegIdxW-1:0] RegZeroLow      = 3'd3;
  localparam logic [RegIdxW-1:0] RegOneLow       = 3'd4;
  localparam logic [RegIdxW-1:0] RegReadLow      = 3'd5;
  localparam logic [RegIdxW-1:0] RegReadSample   = 3'd6;
  localparam logic [RegIdxW-1:0] RegSlotTail     = 3'd7;

  localparam timing_regs_t TimingDefaults = '{
    7: timing_t'(56),
    6: timing_t'(12),
    5: timing_t'(6),
    4: timing_t'(12),
    3: timing_t'(60),
    2: timing_t'(430),
    1: timing_t'(60),
    0: timing_t'(550)
  };

  localparam logic [7:0] CrcPoly = 8'h8C;

  typedef struct packed {
    logic       rejected;
    logic [7:0] crc_value;
    logic [7:0] read_data;
    logic       presence;
    logic       done_res;
    logic       busy_res;
    logic       line_low;
  } result_t;

  function automatic timing_t dur(timing_t t);
    return (t == '0) ? timing_t'(1) : t;
  endfunction

  function automatic logic [7:0] crc_absorb(logic [7:0] crc, logic b);
    logic [7:0] shifted;
    shifted = crc >> 1;
    return (b ^ crc[0]) ? (shifted ^ CrcPoly) : shifted;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/one_wire_bus_master_top.sv =====
// The result word for an input word is registered and appears in the next cycle.
// Throughput: one word per cycle unless the output stalls; one bus step per word.
// The input is taken whenever the output register is empty or being drained.
// Reset: asynchronous, active low; bus state idle, CRC/presence/read byte zero,
// timing registers back to their default values.
`default_nettype none

module one_wire_bus_master_top #(
  parameter int unsigned ZERO_RECOVERY_US = owb_pkg::ZeroRecoveryUsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] write_data, [8] bus_level, [15:9] zero
  input  wire logic [15:0]                 s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]                  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [0] line_low, [1] busy_res, [2] done_res, [3] presence,
  // [11:4] read_data, [19:12] crc_value, [20] rejected, [23:21] zero
  output logic [23:0]                      m_axis_tdata,
  input  wire logic                        cfg_we_i,
  input  wire logic [owb_pkg::RegIdxW-1:0] cfg_idx_i,
  input  wire owb_pkg::timing_t            cfg_wdata_i
);
  import owb_pkg::*;

  timing_regs_t timing_q;
  result_t      result;
  result_t      out_q;
  logic         out_valid_q;
  logic         in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q <= TimingDefaults;
    end else if (cfg_we_i) begin
      timing_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  owb_core #(
    .ZERO_RECOVERY_US(ZERO_RECOVERY_US)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_fire),
    .action_i     (action_e'(s_axis_tuser)),
    .write_data_i (s_axis_tdata[7:0]),
    .bus_level_i  (s_axis_tdata[8]),
    .timing_i     (timing_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

`ifndef SYNTHESIS
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rejected |-> out_q.busy_res)
    else $error("rejected command without a running operation");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res && !out_q.line_low)
    else $error("finished operation still busy");

  a_low_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.line_low |-> out_q.busy_res)
    else $error("line driven low while idle");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted word produced no result");
`endif

endmodule

`default_nettype wire

// ===== rtl/owb_core.sv =====
`default_nettype none

module owb_core #(
  parameter int unsigned ZERO_RECOVERY_US = owb_pkg::ZeroRecoveryUsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire owb_pkg::action_e     action_i,
  input  wire logic [7:0]           write_data_i,
  input  wire logic                 bus_level_i,
  input  wire owb_pkg::timing_regs_t timing_i,
  output owb_pkg::result_t          result_o
);
  import owb_pkg::*;

  typedef enum logic [8:0] {
    PhIdle    = 9'b000000001,
    PhRstLow  = 9'b000000010,
    PhRstWait = 9'b000000100,
    PhRstTail = 9'b000001000,
    PhWLow    = 9'b000010000,
    PhWRec    = 9'b000100000,
    PhRLow    = 9'b001000000,
    PhRWait   = 9'b010000000,
    PhRTail   = 9'b100000000
  } phase_e;

  localparam timing_t ZeroRec = timing_t'(ZERO_RECOVERY_US);

  phase_e     phase_q, phase_d;
  timing_t    time_q, time_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] crc_q, crc_d;
  logic       pres_q, pres_d;
  logic [7:0] rdata_q, rdata_d;
  logic       done, rej, finish;

  always_comb begin
    phase_d = phase_q;
    time_d  = time_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    crc_d   = crc_q;
    pres_d  = pres_q;
    rdata_d = rdata_q;
    done    = 1'b0;
    rej     = 1'b0;
    finish  = 1'b0;
    if (action_i != ActTick) begin
      if (phase_q != PhIdle) begin
        rej = 1'b1;
      end else begin
        unique case (action_i)
          ActReset: begin
            crc_d   = '0;
            pres_d  = 1'b0;
            phase_d = PhRstLow;
            time_d  = dur(timing_i[RegResetLow]);
          end
          ActWrite: begin
            shift_d = write_data_i;
            bit_d   = '0;
            phase_d = PhWLow;
            time_d  = dur(write_data_i[0] ? timing_i[RegOneLow] : timing_i[RegZeroLow]);
          end
          default: begin
            shift_d = '0;
            bit_d   = '0;
            phase_d = PhRLow;
            time_d  = dur(timing_i[RegReadLow]);
          end
        endcase
      end
    end else if (phase_q != PhIdle) begin
      time_d = time_q - timing_t'(1);
      if (time_d == '0) begin
        unique case (phase_q)
          PhRstLow: begin
            phase_d = PhRstWait;
            time_d  = dur(timing_i[RegPresenceWait]);
          end
          PhRstWait: begin
            pres_d  = ~bus_level_i;
            phase_d = PhRstTail;
            time_d  = dur(timing_i[RegPresenceTail]);
          end
          PhWLow: begin
            phase_d = PhWRec;
            time_d  = dur(shift_q[0] ? timing_i[RegSlotTail] : ZeroRec);
          end
          PhWRec: begin
            shift_d = shift_q >> 1;
            if (bit_q == 3'd7) begin
              finish = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = PhWLow;
              time_d  = dur(shift_q[1] ? timing_i[RegOneLow] : timing_i[RegZeroLow]);
            end
          end
          PhRLow: begin
            phase_d = PhRWait;
            time_d  = dur(timing_i[RegReadSample]);
          end
          PhRWait: begin
            shift_d = {bus_level_i, shift_q[7:1]};
            crc_d   = crc_absorb(crc_q, bus_level_i);
            phase_d = PhRTail;
            time_d  = dur(timing_i[RegSlotTail]);
          end
          PhRTail: begin
            if (bit_q == 3'd7) begin
              rdata_d = shift_q;
              finish  = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = PhRLow;
              time_d  = dur(timing_i[RegReadLow]);
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          phase_d = PhIdle;
          time_d  = '0;
          bit_d   = '0;
          done    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      time_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      crc_q   <= '0;
      pres_q  <= 1'b0;
      rdata_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      time_q  <= time_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      crc_q   <= crc_d;
      pres_q  <= pres_d;
      rdata_q <= rdata_d;
    end
  end

  always_comb begin
    result_o.line_low  = (phase_d == PhRstLow) || (phase_d == PhWLow) || (phase_d == PhRLow);
    result_o.busy_res  = (phase_d != PhIdle);
    result_o.done_res  = done;
    result_o.presence  = pres_d;
    result_o.read_data = rdata_d;
    result_o.crc_value = crc_d;
    result_o.rejected  = rej;
  end

endmodule

`default_nettype wire
